// ===== hdl/bitmap_block_allocator_assert.svh =====
// Assertion macros for the bitmap block allocator checker.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BBA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap allocator check failed");

`endif

// ===== hdl/bba_pkg.sv =====
`default_nettype none
package bba_pkg;
	localparam int TOTAL_BLOCKS = 8192;
	localparam int BITMAP_BYTES = 1024;
	localparam int BITMAP_BITS  = BITMAP_BYTES * 8;
	localparam int WORD_W       = 64;
	localparam int ROWS         = BITMAP_BITS / WORD_W;
	localparam int ROW_W        = $clog2(ROWS);
	localparam int BIT_W        = $clog2(WORD_W);
	localparam int IDX_W        = 13;
	localparam int CNT_W        = 14;
	localparam int LIMIT_MAX    = (TOTAL_BLOCKS < BITMAP_BITS) ? TOTAL_BLOCKS : BITMAP_BITS;

	localparam logic [CNT_W-1:0] INDEX_LIMIT  = CNT_W'(LIMIT_MAX);
	localparam logic [CNT_W-1:0] USABLE_RESET = 14'd8192;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef struct packed {
		logic             full;
		logic [BIT_W-1:0] bit_pos;
	} find_t;
endpackage
`default_nettype wire

// ===== hdl/bba_ram.sv =====
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/bba_find.sv =====
`default_nettype none
module bba_find (
	input  wire logic [bba_pkg::WORD_W-1:0] word,
	output bba_pkg::find_t                  res
);
	always_comb begin
		res.full    = &word;
		res.bit_pos = '0;
		for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				res.bit_pos = bba_pkg::BIT_W'(i);
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/bitmap_block_allocator.sv =====
// Free: after accept, SCAN reads the indexed row and checks it, then UPDATE writes it and DONE
// loads the result. Allocate: SCAN goes on to the first bitmap row with a clear bit (or the last row
// with a full bitmap); the scan reads one 64-bit row per cycle.
// One request at a time; in_stall is high from accept to result.
// Reset: usage bitmap reads as all clear (per-row valid flops), no clearing pass;
// used count 0, usable_blocks 8192.
`default_nettype none
module bitmap_block_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [bba_pkg::CNT_W-1:0]  cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       mode,
	input  wire logic [bba_pkg::IDX_W-1:0]  req_block,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            ok,
	output logic      [bba_pkg::IDX_W-1:0]  given_block,
	output logic      [bba_pkg::CNT_W-1:0]  free_count
);
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]                    state_q;
	logic                          mode_q;
	logic [bba_pkg::IDX_W-1:0]     idx_q;
	logic [bba_pkg::ROW_W:0]       rd_cnt_q;
	logic                          chk_vld_q;
	logic [bba_pkg::ROW_W-1:0]     chk_addr_q;
	logic [bba_pkg::ROWS-1:0]      row_valid_q;
	logic [bba_pkg::WORD_W-1:0]    word_q;
	logic [bba_pkg::ROW_W-1:0]     row_q;
	logic [bba_pkg::BIT_W-1:0]     bit_q;
	logic                          hit_q;
	logic [bba_pkg::CNT_W-1:0]     used_q;
	logic [bba_pkg::CNT_W-1:0]     usable_q;
	logic                          res_ok_q;
	logic [bba_pkg::IDX_W-1:0]     res_given_q;
	logic                          out_valid_q;
	logic                          ok_q;
	logic [bba_pkg::IDX_W-1:0]     given_q;
	logic [bba_pkg::CNT_W-1:0]     free_q;

	logic                          rd_en;
	logic [bba_pkg::ROW_W-1:0]     rd_addr;
	logic [bba_pkg::WORD_W-1:0]    rd_data;
	logic [bba_pkg::WORD_W-1:0]    cur_word;
	bba_pkg::find_t                find;
	logic                          wr_en;
	logic [bba_pkg::WORD_W-1:0]    wr_data;
	logic [bba_pkg::WORD_W-1:0]    bit_mask;
	logic [bba_pkg::CNT_W-1:0]     limit;
	logic [bba_pkg::CNT_W-1:0]     pos_ext;
	logic [bba_pkg::CNT_W-1:0]     idx_ext;
	logic                          alloc_ok;
	logic                          free_in_range;
	logic                          free_hit;
	logic                          scan_leave;
	logic                          out_load;

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign given_block = given_q;
	assign free_count  = free_q;

	assign limit    = (usable_q < bba_pkg::INDEX_LIMIT) ? usable_q : bba_pkg::INDEX_LIMIT;
	assign rd_en    = (state_q == ST_SCAN) && !rd_cnt_q[bba_pkg::ROW_W];
	assign rd_addr  = rd_cnt_q[bba_pkg::ROW_W-1:0];
	assign cur_word = row_valid_q[chk_addr_q] ? rd_data : '0;

	assign scan_leave = chk_vld_q && ((mode_q == bba_pkg::MODE_FREE) || !find.full ||
		(chk_addr_q == bba_pkg::ROW_W'(bba_pkg::ROWS - 1)));

	assign bit_mask      = bba_pkg::WORD_W'(1) << bit_q;
	assign pos_ext       = bba_pkg::CNT_W'({row_q, bit_q});
	assign idx_ext       = bba_pkg::CNT_W'(idx_q);
	assign alloc_ok      = hit_q && (pos_ext < limit) && (used_q < limit);
	assign free_in_range = idx_ext < bba_pkg::INDEX_LIMIT;
	assign free_hit      = free_in_range && ((word_q & bit_mask) != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = word_q;
		if (state_q == ST_UPDATE) begin
			if (mode_q == bba_pkg::MODE_ALLOC) begin
				wr_en   = alloc_ok;
				wr_data = word_q | bit_mask;
			end else begin
				wr_en   = free_hit;
				wr_data = word_q & ~bit_mask;
			end
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	bba_find u_find (
		.word (cur_word),
		.res  (find)
	);

	bba_ram #(
		.WIDTH (bba_pkg::WORD_W),
		.DEPTH (bba_pkg::ROWS)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (row_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			chk_vld_q   <= 1'b0;
			row_valid_q <= '0;
			used_q      <= '0;
			usable_q    <= bba_pkg::USABLE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				usable_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					chk_vld_q <= 1'b0;
					if (in_valid) begin
						rd_cnt_q <= (mode == bba_pkg::MODE_FREE)
							? (bba_pkg::ROW_W + 1)'(req_block >> bba_pkg::BIT_W) : '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_vld_q <= rd_en && !scan_leave;
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (scan_leave) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (wr_en) begin
						row_valid_q[row_q] <= 1'b1;
					end
					if (mode_q == bba_pkg::MODE_ALLOC) begin
						if (alloc_ok) begin
							used_q <= used_q + 1'b1;
						end
					end else if (free_hit && (used_q != '0)) begin
						used_q <= used_q - 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			mode_q <= mode;
			idx_q  <= req_block;
		end
		if (state_q == ST_SCAN) begin
			chk_addr_q <= rd_addr;
			if (scan_leave) begin
				word_q <= cur_word;
				row_q  <= chk_addr_q;
				if (mode_q == bba_pkg::MODE_FREE) begin
					bit_q <= idx_q[bba_pkg::BIT_W-1:0];
					hit_q <= 1'b1;
				end else begin
					bit_q <= find.bit_pos;
					hit_q <= !find.full;
				end
			end
		end
		if (state_q == ST_UPDATE) begin
			if (mode_q == bba_pkg::MODE_ALLOC) begin
				res_ok_q    <= alloc_ok;
				res_given_q <= alloc_ok ? bba_pkg::IDX_W'(pos_ext) : '0;
			end else begin
				res_ok_q    <= free_in_range;
				res_given_q <= '0;
			end
		end
		if (out_load) begin
			ok_q    <= res_ok_q;
			given_q <= res_given_q;
			free_q  <= (used_q < limit) ? (limit - used_q) : '0;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/bba_checker.sv =====
`default_nettype none
`include "bitmap_block_allocator_assert.svh"
module bba_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire logic                      mode,
	input wire logic [bba_pkg::IDX_W-1:0] req_block,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic                      ok,
	input wire logic [bba_pkg::IDX_W-1:0] given_block,
	input wire logic [bba_pkg::CNT_W-1:0] free_count
);
	`BBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`BBA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(mode) && $stable(req_block))
	`BBA_ASSERT_NOW(a_fail_gives_zero, out_valid && !ok, given_block == '0)
	`BBA_ASSERT_NOW(a_free_count_bound, out_valid, free_count <= bba_pkg::INDEX_LIMIT)
	`BBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(ok) && $stable(given_block) && $stable(free_count))
endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
`default_nettype wire
